@@ sv/blese_pkg.sv @@
// shared types, codes and constants of the ble slave event scheduler
// no dependencies; imported by blese_sched and ble_slave_event_scheduler_core
`default_nettype none

package blese_pkg;

  // time units in 4 MHz radio ticks
  localparam int unsigned ADV_UNIT_TICKS     = 2500;
  localparam int unsigned CONN_UNIT_TICKS    = 5000;
  localparam int unsigned EARLY_OFFSET_LIMIT = 60000;
  localparam int unsigned EARLY_OFFSET_UNITS = EARLY_OFFSET_LIMIT / CONN_UNIT_TICKS;
  localparam int unsigned NUM_DATA_CHANNELS  = 37;
  localparam int unsigned START_LEAD         = 4000;
  localparam int unsigned WAKE_LEAD          = 12000;

  localparam logic [3:0] PDU_CONNECT_REQ = 4'd5;

  // configuration port
  localparam int unsigned CFG_ADDR_W  = 1;
  localparam int unsigned CFG_DATA_W  = 15;
  localparam int unsigned ADV_IV_W    = 27;  // 32767 * 2500 fits
  localparam int unsigned ADV_EN_W    = 3;
  localparam int unsigned ADV_IVU_RST = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADV_INTERVAL = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADV_CHANNELS = 1'd1;

  // request kinds
  localparam logic [1:0] KIND_ADV_ENABLE = 2'd0;
  localparam logic [1:0] KIND_TIMER      = 2'd1;
  localparam logic [1:0] KIND_RX_PACKET  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERROR   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef enum logic [1:0] {
    MODE_STANDBY = 2'd0,
    MODE_ADV     = 2'd1,
    MODE_CONN    = 2'd2
  } mode_t;

  // request after the stateless precompute stages
  typedef struct packed {
    logic [1:0]  kind;
    logic        enable;
    logic        conn_req;   // pdu type is connect request
    logic        radio_ok;
    logic [4:0]  hop;
    logic [5:0]  hop2;       // channel after one hop from hop
    logic        early;      // offset too small, first event skipped
    logic [20:0] win_ticks;
    logic [31:0] iv_ticks;
    logic [31:0] first_anchor;
    logic [31:0] next_anchor;
    logic [31:0] pred_anchor; // anchor that follows the stored counter
    logic [31:0] adv_start;   // now plus advertising interval
  } prep_t;

  // result before the final lead subtraction
  typedef struct packed {
    logic [1:0]  status;
    mode_t       mode;
    logic [2:0]  adv_ch;
    logic [5:0]  channel;
    logic [15:0] event_cnt;
    logic        rs_en;
    logic [31:0] rs_anchor;
    logic [20:0] win_ticks;
    logic        armed;
    logic        wake;       // compare is an anchor, subtract wake lead
    logic [31:0] tc_value;
    logic        issued;
  } res_t;

  function automatic logic [5:0] hop_add(input logic [5:0] ch, input logic [4:0] hop);
    logic [6:0] s;
    s = 7'(ch) + 7'(hop);
    if (s >= 7'(NUM_DATA_CHANNELS)) begin
      s = s - 7'(NUM_DATA_CHANNELS);
    end
    return s[5:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/blese_sched.sv @@
// mode and timing state of the scheduler with the registered result stage
// depends on blese_pkg
`default_nettype none

module blese_sched
  import blese_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                item_go,
  input  wire prep_t               item,
  input  wire logic [ADV_IV_W-1:0] adv_iv,
  input  wire logic [ADV_EN_W-1:0] adv_en,
  output res_t                     res_r
);

  mode_t       mode_r, mode_nxt;
  logic [31:0] next_adv_r, next_adv_nxt;
  logic [31:0] interval_r, interval_nxt;
  logic [4:0]  hop_r, hop_nxt;
  logic [5:0]  chan_r, chan_nxt;
  logic [15:0] ecnt_r, ecnt_nxt;
  logic [31:0] anchor_r, anchor_nxt;
  logic [20:0] rxwin_r, rxwin_nxt;
  logic [31:0] fa_iv_r, fa_iv_nxt;     // first anchor plus one interval
  logic [31:0] pred_r, pred_nxt;       // first anchor + interval * (counter + 1)
  res_t        res_nxt;

  logic [15:0] ecnt_inc;
  logic [31:0] pred_step;
  logic [31:0] adv_step;

  assign ecnt_inc  = ecnt_r + 16'd1;
  assign pred_step = (ecnt_inc == 16'd0) ? fa_iv_r : pred_r + interval_r;
  assign adv_step  = next_adv_r + 32'(adv_iv);

  // mode transitions
  always_comb begin
    mode_nxt = mode_r;
    case (item.kind)
      KIND_ADV_ENABLE: begin
        if (item.enable && mode_r == MODE_STANDBY) begin
          mode_nxt = MODE_ADV;
        end else if (!item.enable && mode_r == MODE_ADV) begin
          mode_nxt = MODE_STANDBY;
        end
      end
      KIND_RX_PACKET: begin
        if (mode_r == MODE_ADV && item.conn_req) begin
          mode_nxt = item.radio_ok ? MODE_CONN : MODE_STANDBY;
        end
      end
      default: mode_nxt = mode_r;
    endcase
  end

  // timing state and result fields
  always_comb begin
    next_adv_nxt = next_adv_r;
    interval_nxt = interval_r;
    hop_nxt      = hop_r;
    chan_nxt     = chan_r;
    ecnt_nxt     = ecnt_r;
    anchor_nxt   = anchor_r;
    rxwin_nxt    = rxwin_r;
    fa_iv_nxt    = fa_iv_r;
    pred_nxt     = pred_r;
    res_nxt      = '0;
    res_nxt.status = ST_IGNORED;
    case (item.kind)
      KIND_ADV_ENABLE: begin
        if (item.enable && mode_r == MODE_STANDBY) begin
          next_adv_nxt     = item.adv_start;
          res_nxt.tc_value = item.adv_start;
          res_nxt.armed    = 1'b1;
          res_nxt.status   = ST_OK;
        end else if (!item.enable && mode_r == MODE_ADV) begin
          res_nxt.status = ST_OK;
        end else begin
          res_nxt.status = ST_ERROR;
        end
      end
      KIND_TIMER: begin
        if (mode_r == MODE_ADV) begin
          res_nxt.adv_ch   = adv_en;
          next_adv_nxt     = adv_step;
          res_nxt.tc_value = adv_step;
          res_nxt.armed    = 1'b1;
          res_nxt.status   = ST_OK;
        end else if (mode_r == MODE_CONN) begin
          ecnt_nxt          = ecnt_inc;
          chan_nxt          = hop_add(chan_r, hop_r);
          pred_nxt          = pred_step;
          res_nxt.rs_en     = 1'b1;
          res_nxt.rs_anchor = anchor_r;
          if (item.radio_ok) begin
            anchor_nxt       = pred_step;
            res_nxt.tc_value = pred_step;
            res_nxt.wake     = 1'b1;
            res_nxt.armed    = 1'b1;
            res_nxt.issued   = 1'b1;
            res_nxt.status   = ST_OK;
          end else begin
            res_nxt.status = ST_ERROR;
          end
        end
      end
      KIND_RX_PACKET: begin
        if (mode_r == MODE_ADV && item.conn_req) begin
          rxwin_nxt         = item.win_ticks;
          interval_nxt      = item.iv_ticks;
          hop_nxt           = item.hop;
          ecnt_nxt          = item.early ? 16'd1 : 16'd0;
          chan_nxt          = item.early ? item.hop2 : 6'(item.hop);
          fa_iv_nxt         = item.next_anchor;
          pred_nxt          = item.pred_anchor;
          res_nxt.rs_en     = 1'b1;
          res_nxt.rs_anchor = item.first_anchor;
          if (item.radio_ok) begin
            anchor_nxt       = item.next_anchor;
            res_nxt.tc_value = item.next_anchor;
            res_nxt.wake     = 1'b1;
            res_nxt.armed    = 1'b1;
            res_nxt.issued   = 1'b1;
            res_nxt.status   = ST_OK;
          end else begin
            res_nxt.status = ST_ERROR;
          end
        end
      end
      default: res_nxt.status = ST_IGNORED;
    endcase
    res_nxt.mode      = mode_nxt;
    res_nxt.channel   = chan_nxt;
    res_nxt.event_cnt = ecnt_nxt;
    res_nxt.win_ticks = rxwin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_STANDBY;
      next_adv_r <= '0;
      interval_r <= '0;
      hop_r      <= '0;
      chan_r     <= '0;
      ecnt_r     <= '0;
      anchor_r   <= '0;
      rxwin_r    <= '0;
      fa_iv_r    <= '0;
      pred_r     <= '0;
    end else if (item_go) begin
      mode_r     <= mode_nxt;
      next_adv_r <= next_adv_nxt;
      interval_r <= interval_nxt;
      hop_r      <= hop_nxt;
      chan_r     <= chan_nxt;
      ecnt_r     <= ecnt_nxt;
      anchor_r   <= anchor_nxt;
      rxwin_r    <= rxwin_nxt;
      fa_iv_r    <= fa_iv_nxt;
      pred_r     <= pred_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_go) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/ble_slave_event_scheduler_core.sv @@
// top level of the ble slave link-layer mode and timing sequencer
// depends on blese_pkg and blese_sched
`default_nettype none

// usage
//  in_* carries one request per handshake: in_tuser is the request kind
//  (advertise enable, timer compare event, received advertising packet),
//  in_tdata holds the request fields. out_* returns exactly one result per
//  request, in request order. cfg_* writes the advertising interval and the
//  advertising channel mask; write them only while no request is in flight.
//  pipeline: a request passes the product stage, anchor-sum stage, state stage
//  and lead-subtract stage, each registered, before its result is valid
//  throughput: one request per cycle unless stalled; the mode/timing state is updated in
//  the single state stage, every other stage only sees one request
//  reset: mode standby, all times and counters zero, interval 32 units,
//  all three advertising channels enabled, pipeline empty
//  stall: while out_tready is low the result holds and the stages behind it
//  keep filling; in_tready drops only when all four stages hold a request
//  all time arithmetic wraps modulo 2^32

module ble_slave_event_scheduler_core
  import blese_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // enable[0], now_ticks[32:1], pdu_type[36:33], window_units[44:37],
  // offset_units[60:45], interval_units[76:61], hop_increment[81:77],
  // rx_timestamp[113:82], radio_ok[114], zero[119:115]
  input  wire logic [119:0]          in_tdata,
  // kind[1:0]
  input  wire logic [1:0]            in_tuser,
  // result channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // status[1:0], mode_now[3:2], adv_channels[6:4], data_channel[12:7],
  // event_count[28:13], radio_start[60:29], window_ticks[81:61],
  // timer_compare[113:82], timer_armed[114], command_issued[115], zero[119:116]
  output logic [119:0]               out_tdata,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration, interval kept in ticks
  logic [ADV_IV_W-1:0] adv_iv_r;
  logic [ADV_EN_W-1:0] adv_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adv_iv_r <= ADV_IV_W'(ADV_IVU_RST * ADV_UNIT_TICKS);
      adv_en_r <= '1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ADV_INTERVAL: adv_iv_r <= ADV_IV_W'(cfg_wdata) * ADV_IV_W'(ADV_UNIT_TICKS);
        CFG_ADV_CHANNELS: adv_en_r <= cfg_wdata[ADV_EN_W-1:0];
        default: adv_en_r <= adv_en_r;
      endcase
    end
  end

  // stage handshake: each stage takes a new request when empty or draining
  logic a_v_r, b_v_r, c_v_r, out_v_r;
  logic a_rdy, b_rdy, c_rdy, d_rdy;
  logic a_go, b_go, c_go, d_go;

  assign d_rdy     = !out_v_r || out_tready;
  assign c_rdy     = !c_v_r || d_rdy;
  assign b_rdy     = !b_v_r || c_rdy;
  assign a_rdy     = !a_v_r || b_rdy;
  assign in_tready = a_rdy;
  assign a_go      = in_tvalid && a_rdy;
  assign b_go      = a_v_r && b_rdy;
  assign c_go      = b_v_r && c_rdy;
  assign d_go      = c_v_r && d_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      a_v_r   <= a_go || (a_v_r && !b_go);
      b_v_r   <= b_go || (b_v_r && !c_go);
      c_v_r   <= c_go || (c_v_r && !d_go);
      out_v_r <= d_go || (out_v_r && !out_tready);
    end
  end

  // request fields
  logic        in_enable, in_ok;
  logic [31:0] in_now, in_stamp;
  logic [3:0]  in_pdu;
  logic [7:0]  in_win;
  logic [15:0] in_off, in_int;
  logic [4:0]  in_hop;

  assign in_enable = in_tdata[0];
  assign in_now    = in_tdata[32:1];
  assign in_pdu    = in_tdata[36:33];
  assign in_win    = in_tdata[44:37];
  assign in_off    = in_tdata[60:45];
  assign in_int    = in_tdata[76:61];
  assign in_hop    = in_tdata[81:77];
  assign in_stamp  = in_tdata[113:82];
  assign in_ok     = in_tdata[114];

  // stage a: unit conversions by constant products
  logic [1:0]  a_kind_r;
  logic        a_enable_r, a_conn_r, a_ok_r, a_early_r;
  logic [4:0]  a_hop_r;
  logic [5:0]  a_hop2_r;
  logic [20:0] a_win_r;
  logic [31:0] a_off_r, a_iv_r, a_iv2_r, a_iv3_r, a_stamp_r, a_now_r;

  always_ff @(posedge clk) begin
    if (a_go) begin
      a_kind_r   <= in_tuser;
      a_enable_r <= in_enable;
      a_conn_r   <= (in_pdu == PDU_CONNECT_REQ);
      a_ok_r     <= in_ok;
      a_early_r  <= (in_off <= 16'(EARLY_OFFSET_UNITS));
      a_hop_r    <= in_hop;
      a_hop2_r   <= hop_add(6'(in_hop), in_hop);
      a_win_r    <= 21'(in_win) * 21'(CONN_UNIT_TICKS);
      a_off_r    <= 32'(in_off) * 32'(CONN_UNIT_TICKS);
      a_iv_r     <= 32'(in_int) * 32'(CONN_UNIT_TICKS);
      a_iv2_r    <= 32'(in_int) * 32'(2 * CONN_UNIT_TICKS);
      a_iv3_r    <= 32'(in_int) * 32'(3 * CONN_UNIT_TICKS);
      a_stamp_r  <= in_stamp;
      a_now_r    <= in_now;
    end
  end

  // stage b: connection anchors, all independent of the state
  // not early: first = fa0, next = fa0 + iv, pred = fa0 + iv
  // early:     first = fa0 + iv, next = fa0 + 2iv, pred = fa0 + 3iv
  logic [31:0] fa0;
  prep_t       b_nxt, b_r;

  assign fa0 = a_stamp_r + a_off_r;

  always_comb begin
    b_nxt.kind         = a_kind_r;
    b_nxt.enable       = a_enable_r;
    b_nxt.conn_req     = a_conn_r;
    b_nxt.radio_ok     = a_ok_r;
    b_nxt.hop          = a_hop_r;
    b_nxt.hop2         = a_hop2_r;
    b_nxt.early        = a_early_r;
    b_nxt.win_ticks    = a_win_r;
    b_nxt.iv_ticks     = a_iv_r;
    b_nxt.first_anchor = a_early_r ? fa0 + a_iv_r : fa0;
    b_nxt.next_anchor  = fa0 + (a_early_r ? a_iv2_r : a_iv_r);
    b_nxt.pred_anchor  = fa0 + (a_early_r ? a_iv3_r : a_iv_r);
    b_nxt.adv_start    = a_now_r + 32'(adv_iv_r);
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      b_r <= b_nxt;
    end
  end

  // stage c: mode and timing state
  res_t c_res;

  blese_sched u_sched (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_go (c_go),
    .item    (b_r),
    .adv_iv  (adv_iv_r),
    .adv_en  (adv_en_r),
    .res_r   (c_res)
  );

  // stage d: radio start and wake-up leads, output register
  logic [31:0]  d_rstart, d_tcomp;
  logic [119:0] out_data_r;

  assign d_rstart = c_res.rs_en ? c_res.rs_anchor - 32'(START_LEAD) : 32'd0;
  assign d_tcomp  = !c_res.armed ? 32'd0 :
                    c_res.wake ? c_res.tc_value - 32'(WAKE_LEAD) : c_res.tc_value;

  always_ff @(posedge clk) begin
    if (d_go) begin
      out_data_r <= {4'd0, c_res.issued, c_res.armed, d_tcomp, c_res.win_ticks,
                     d_rstart, c_res.event_cnt, c_res.channel, c_res.adv_ch,
                     2'(c_res.mode), c_res.status};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // a stalled input means every stage holds a request
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (a_v_r && b_v_r && c_v_r && out_v_r))
    else $error("input stalled with an empty stage");

  // an issued slave command means the connection is up and the result is ok
  a_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_tdata[115]) |->
      (out_tdata[1:0] == ST_OK && out_tdata[3:2] == 2'(MODE_CONN)))
    else $error("command issued outside connected mode");

  // data channel stays below the channel count
  a_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_tdata[12:7] < 6'(NUM_DATA_CHANNELS)))
    else $error("data channel out of range");

  // compare value is zero unless the timer is armed
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tdata[114]) |-> (out_tdata[113:82] == 32'd0))
    else $error("timer compare without arm");

  // advertising channels are only reported while advertising
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_tdata[6:4] != 3'd0) |-> (out_tdata[3:2] == 2'(MODE_ADV)))
    else $error("advertising channels outside advertising mode");

endmodule

`default_nettype wire
